// ----- rtl/gclu_pkg.sv -----
// Shared constants and types for the gain-clamp linear upsampler.
package gclu_pkg;

  // Number of output samples produced for each input item.
  localparam int unsigned INTERP_FACTOR = 6;

  // Field widths.
  localparam int unsigned IN_W  = 16;
  localparam int unsigned OUT_W = 15;
  // Magnitude of a safe sample or of a difference of two safe samples (up to 20000).
  localparam int unsigned MAG_W = 15;

  // Gain of 3/5 and the clamp level.
  localparam int unsigned SAFE_PEAK = 10000;
  localparam int unsigned GAIN_NUM  = 3;
  localparam int unsigned GAIN_DEN  = 5;
  // Magnitude after the multiply by the numerator (up to 98304).
  localparam int unsigned SCALED_W  = 17;

  // Division by the gain denominator as a multiply by a rounded-up reciprocal.
  localparam int unsigned GAIN_SHIFT   = 20;
  localparam int unsigned GAIN_RECIP   = (2 ** GAIN_SHIFT + GAIN_DEN - 1) / GAIN_DEN;
  localparam int unsigned GAIN_RECIP_W = 18;
  localparam int unsigned GAIN_PROD_W  = SCALED_W + GAIN_RECIP_W;

  // Division by the interpolation factor, same technique.
  localparam int unsigned PHASE_SHIFT   = 20;
  localparam int unsigned PHASE_RECIP   = (2 ** PHASE_SHIFT + INTERP_FACTOR - 1) / INTERP_FACTOR;
  localparam int unsigned PHASE_RECIP_W = 20;
  localparam int unsigned PHASE_PROD_W  = MAG_W + PHASE_RECIP_W;

  // Phase counter runs 1..INTERP_FACTOR; remainders run 0..INTERP_FACTOR-1.
  localparam int unsigned PHASE_W = $clog2(INTERP_FACTOR + 1);
  localparam int unsigned REM_W   = $clog2(INTERP_FACTOR);

  // Queue between the front and the back.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One classified item: start point, direction and size of the step.
  typedef struct packed {
    logic [OUT_W-1:0] prev;  // previous safe sample, two's complement
    logic             neg;   // new sample lies below the previous one
    logic [MAG_W-1:0] mag;   // magnitude of the difference
    logic [MAG_W-1:0] quo;   // magnitude divided by the interpolation factor
  } gclu_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } gclu_fifo_stat_t;

endpackage

// ----- rtl/gclu_front.sv -----
// Front part: scales and clamps each input sample and computes the step to the new sample.
module gclu_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [gclu_pkg::IN_W-1:0] in_sample_i,
  input  gclu_pkg::gclu_fifo_stat_t   stat_i,
  output logic                        push_o,
  output gclu_pkg::gclu_entry_t       push_data_o
);

  logic                               accept;
  logic                               in_neg;
  logic [gclu_pkg::IN_W-1:0]          in_mag;
  logic [gclu_pkg::SCALED_W-1:0]      scaled;
  logic [gclu_pkg::GAIN_PROD_W-1:0]   gain_prod;
  logic [gclu_pkg::MAG_W-1:0]         quot_mag;
  logic [gclu_pkg::MAG_W-1:0]         clamp_mag;
  logic [gclu_pkg::OUT_W-1:0]         safe_d, safe_q;
  logic                               s1_vld_d, s1_vld_q;
  logic [gclu_pkg::OUT_W-1:0]         prev_d, prev_q;
  logic [gclu_pkg::OUT_W:0]           delta;
  logic                               d_neg;
  logic [gclu_pkg::OUT_W:0]           d_abs;
  logic [gclu_pkg::MAG_W-1:0]         d_mag;
  logic [gclu_pkg::PHASE_PROD_W-1:0]  phase_prod;

  // The first stage holds one item; it moves on when the queue has room.
  assign push_o     = s1_vld_q && !stat_i.full;
  assign in_stall_o = s1_vld_q && stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Scale the magnitude by 3/5 with truncation, clamp it and restore the sign.
  always_comb begin
    in_neg    = in_sample_i[gclu_pkg::IN_W-1];
    in_mag    = in_neg ? (~in_sample_i + 1'b1) : in_sample_i;
    scaled    = gclu_pkg::SCALED_W'(in_mag) * gclu_pkg::SCALED_W'(gclu_pkg::GAIN_NUM);
    gain_prod = gclu_pkg::GAIN_PROD_W'(scaled) *
                gclu_pkg::GAIN_PROD_W'(gclu_pkg::GAIN_RECIP);
    quot_mag  = gain_prod[gclu_pkg::GAIN_SHIFT +: gclu_pkg::MAG_W];
    clamp_mag = (quot_mag > gclu_pkg::MAG_W'(gclu_pkg::SAFE_PEAK)) ?
                gclu_pkg::MAG_W'(gclu_pkg::SAFE_PEAK) : quot_mag;
    safe_d    = in_neg ? (~clamp_mag + 1'b1) : clamp_mag;
  end

  // Difference to the previous safe sample and its division by the factor.
  always_comb begin
    delta      = {safe_q[gclu_pkg::OUT_W-1], safe_q} - {prev_q[gclu_pkg::OUT_W-1], prev_q};
    d_neg      = delta[gclu_pkg::OUT_W];
    d_abs      = d_neg ? (~delta + 1'b1) : delta;
    d_mag      = d_abs[gclu_pkg::MAG_W-1:0];
    phase_prod = gclu_pkg::PHASE_PROD_W'(d_mag) *
                 gclu_pkg::PHASE_PROD_W'(gclu_pkg::PHASE_RECIP);
    push_data_o.prev = prev_q;
    push_data_o.neg  = d_neg;
    push_data_o.mag  = d_mag;
    push_data_o.quo  = phase_prod[gclu_pkg::PHASE_SHIFT +: gclu_pkg::MAG_W];
  end

  // Stage valid and the stored previous sample.
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (push_o) begin
      s1_vld_d = 1'b0;
    end
    prev_d = push_o ? safe_q : prev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      prev_q   <= '0;
    end else begin
      s1_vld_q <= s1_vld_d;
      prev_q   <= prev_d;
    end
  end

  // Payload of the first stage.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      safe_q <= safe_d;
    end
  end

endmodule

// ----- rtl/gclu_fifo.sv -----
// Short queue of classified items between the front and the back.
module gclu_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  gclu_pkg::gclu_entry_t     push_data_i,
  input  logic                      pop_i,
  output gclu_pkg::gclu_entry_t     pop_data_o,
  output gclu_pkg::gclu_fifo_stat_t stat_o
);

  gclu_pkg::gclu_entry_t              mem_q [gclu_pkg::FIFO_DEPTH];
  logic [gclu_pkg::FIFO_PTR_W-1:0]    wr_ptr_d, wr_ptr_q;
  logic [gclu_pkg::FIFO_PTR_W-1:0]    rd_ptr_d, rd_ptr_q;
  logic [gclu_pkg::FIFO_CNT_W-1:0]    cnt_d, cnt_q;

  assign stat_o.full  = (cnt_q == gclu_pkg::FIFO_CNT_W'(gclu_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == gclu_pkg::FIFO_PTR_W'(gclu_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == gclu_pkg::FIFO_PTR_W'(gclu_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/gclu_back.sv -----
// Back part: walks each item's interpolation phases, one result per cycle if unstalled.
module gclu_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gclu_pkg::gclu_fifo_stat_t        stat_i,
  input  gclu_pkg::gclu_entry_t            pop_data_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [gclu_pkg::OUT_W-1:0] out_sample_o,
  output logic                             last_o
);

  logic                              busy_d, busy_q;
  logic [gclu_pkg::PHASE_W-1:0]      phase_d, phase_q;
  logic [gclu_pkg::OUT_W-1:0]        prev_d, prev_q;
  logic                              neg_d, neg_q;
  logic [gclu_pkg::MAG_W-1:0]        quo_d, quo_q;
  logic [gclu_pkg::REM_W-1:0]        rem_step_d, rem_step_q;
  logic [gclu_pkg::MAG_W-1:0]        q_acc_d, q_acc_q;
  logic [gclu_pkg::REM_W-1:0]        r_acc_d, r_acc_q;
  logic                              out_vld_d, out_vld_q;
  logic [gclu_pkg::OUT_W-1:0]        out_sample_q;
  logic                              out_last_q;

  logic                              adv;
  logic                              last_phase;
  logic [gclu_pkg::MAG_W-1:0]        ld_rem;
  logic [gclu_pkg::REM_W:0]          r_sum;
  logic                              carry;
  logic [gclu_pkg::REM_W-1:0]        r_next;
  logic [gclu_pkg::MAG_W-1:0]        q_next;
  logic [gclu_pkg::OUT_W:0]          value;

  // A phase is produced when the output register is free or being emptied.
  assign last_phase = (phase_q == gclu_pkg::PHASE_W'(gclu_pkg::INTERP_FACTOR));
  assign adv        = busy_q && (!out_vld_q || !out_stall_i);
  assign pop_o      = !stat_i.empty && (!busy_q || (adv && last_phase));

  // Remainder of the step size, from the registered queue entry.
  assign ld_rem = pop_data_i.mag -
                  gclu_pkg::MAG_W'(pop_data_i.quo * gclu_pkg::MAG_W'(gclu_pkg::INTERP_FACTOR));

  // Running quotient and remainder of difference times phase over the factor.
  always_comb begin
    r_sum  = {1'b0, r_acc_q} + {1'b0, rem_step_q};
    carry  = (r_sum >= (gclu_pkg::REM_W + 1)'(gclu_pkg::INTERP_FACTOR));
    r_next = carry ? gclu_pkg::REM_W'(r_sum - (gclu_pkg::REM_W + 1)'(gclu_pkg::INTERP_FACTOR)) :
                     gclu_pkg::REM_W'(r_sum);
    q_next = q_acc_q + quo_q + gclu_pkg::MAG_W'(carry);
    value  = neg_q ? ({prev_q[gclu_pkg::OUT_W-1], prev_q} - {1'b0, q_next}) :
                     ({prev_q[gclu_pkg::OUT_W-1], prev_q} + {1'b0, q_next});
  end

  // Sequencer: load an item, then walk its phases.
  always_comb begin
    busy_d     = busy_q;
    phase_d    = phase_q;
    prev_d     = prev_q;
    neg_d      = neg_q;
    quo_d      = quo_q;
    rem_step_d = rem_step_q;
    q_acc_d    = q_acc_q;
    r_acc_d    = r_acc_q;
    if (pop_o) begin
      busy_d     = 1'b1;
      phase_d    = gclu_pkg::PHASE_W'(1);
      prev_d     = pop_data_i.prev;
      neg_d      = pop_data_i.neg;
      quo_d      = pop_data_i.quo;
      rem_step_d = ld_rem[gclu_pkg::REM_W-1:0];
      q_acc_d    = '0;
      r_acc_d    = '0;
    end else if (adv) begin
      phase_d = phase_q + 1'b1;
      q_acc_d = q_next;
      r_acc_d = r_next;
      if (last_phase) begin
        busy_d = 1'b0;
      end
    end
  end

  // Output register valid.
  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      phase_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      phase_q   <= phase_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Item and output payload.
  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    neg_q      <= neg_d;
    quo_q      <= quo_d;
    rem_step_q <= rem_step_d;
    q_acc_q    <= q_acc_d;
    r_acc_q    <= r_acc_d;
    if (adv) begin
      out_sample_q <= value[gclu_pkg::OUT_W-1:0];
      out_last_q   <= last_phase;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_sample_o = out_sample_q;
  assign last_o       = out_last_q;

endmodule

// ----- rtl/gain_clamp_linear_upsampler_x6.sv -----
// Top level of the gain-clamp linear upsampler: front, queue and back.
// An item's first result passes the front stage register, the queue entry and the
// back part's item registers into the output register. The back part gives one result
// per cycle unless the output stalls, six results per item, via its one output register.
// The front takes a new item every cycle while the two-entry queue has room.
// Reset clears all valid flags and the stored previous sample to zero.
module gain_clamp_linear_upsampler_x6 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [gclu_pkg::IN_W-1:0]  in_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [gclu_pkg::OUT_W-1:0] out_sample_o,
  output logic                              last_o
);

  gclu_pkg::gclu_fifo_stat_t fifo_stat;
  gclu_pkg::gclu_entry_t     push_data;
  gclu_pkg::gclu_entry_t     pop_data;
  logic                      push;
  logic                      pop;

  // Scaling, clamping and step computation.
  gclu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_sample_i (in_sample_i),
    .stat_i      (fifo_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decoupling queue.
  gclu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  // Phase sequencer and output register.
  gclu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stat_i       (fifo_stat),
    .pop_data_i   (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_sample_o (out_sample_o),
    .last_o       (last_o)
  );

endmodule

// ----- rtl/gclu_checker.sv -----
// Port-level checks for the gain-clamp linear upsampler, bound to the top level.
module gclu_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [gclu_pkg::OUT_W-1:0] out_sample_o,
  input logic                              last_o
);

  localparam int unsigned PEND_W = 4;

  logic                         in_acc;
  logic                         out_acc;
  logic [gclu_pkg::PHASE_W-1:0] seen_d, seen_q;
  logic [PEND_W-1:0]            pend_d, pend_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Results taken so far in the current group, and items whose group is not finished.
  always_comb begin
    seen_d = seen_q;
    pend_d = pend_q;
    if (out_acc) begin
      seen_d = last_o ? '0 : seen_q + 1'b1;
    end
    if (in_acc && !(out_acc && last_o)) begin
      pend_d = pend_q + 1'b1;
    end else if (!in_acc && out_acc && last_o) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      pend_q <= '0;
    end else begin
      seen_q <= seen_d;
      pend_q <= pend_d;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_sample_o) && $stable(last_o))
    else $error("stalled result changed");

  // Results stay inside the clamp range.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_sample_o <= 15'sd10000) && (out_sample_o >= -15'sd10000))
    else $error("result outside clamp range");

  // The flag marks exactly the final result of each group.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (last_o == (seen_q == gclu_pkg::PHASE_W'(gclu_pkg::INTERP_FACTOR - 1))))
    else $error("last flag out of place");

  // No result appears without an unfinished item behind it.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != '0))
    else $error("result without a pending item");

endmodule

bind gain_clamp_linear_upsampler_x6 gclu_checker u_gclu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_sample_o (out_sample_o),
  .last_o       (last_o)
);

// ----- tb/tb_gain_clamp_linear_upsampler_x6.sv -----
// Testbench for the gain-clamp linear upsampler: directed and random samples with a predictor.
module tb_gain_clamp_linear_upsampler_x6;
  timeunit 1ns;
  timeprecision 1ps;

  import gclu_pkg::*;

  // Signed copies of the package constants, so the predictor never mixes in unsigned math.
  localparam int Phases   = int'(INTERP_FACTOR);
  localparam int Peak     = int'(SAFE_PEAK);
  localparam int GainNum  = int'(GAIN_NUM);
  localparam int GainDen  = int'(GAIN_DEN);
  // Cycles without any accepted item before the run is declared hung.
  localparam int QuietLimit = 2000;
  // Cycles to wait after the last result, a few times the block's latency.
  localparam int TailCycles = 12;

  // One expected output sample.
  typedef struct {
    logic signed [OUT_W-1:0] sample;
    logic                    last;
  } pcm_out_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic signed [IN_W-1:0]  in_sample_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] out_sample_o;
  logic                    last_o;

  // Expected samples in output order, and the predictor's stored safe sample.
  pcm_out_t pending_pcm_q[$];
  int       held_safe   = 0;
  int       fail_count  = 0;
  int       quiet_count = 0;
  int       src_idle_pct = 0;
  int       snk_stall_pct = 0;

  gain_clamp_linear_upsampler_x6 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_sample_i (in_sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_sample_o(out_sample_o),
    .last_o      (last_o)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Scale by three fifths toward zero, then clamp to the safe range.
  function automatic int gain_clamp(input logic signed [IN_W-1:0] s);
    int scaled;
    scaled = (int'(s) * GainNum) / GainDen;
    if (scaled > Peak) scaled = Peak;
    if (scaled < -Peak) scaled = -Peak;
    return scaled;
  endfunction

  // Queue the six interpolated samples that one input causes and update the stored sample.
  function automatic void predict_interp_group(input logic signed [IN_W-1:0] s);
    int       safe;
    int       delta;
    int       v;
    pcm_out_t e;
    safe  = gain_clamp(s);
    delta = safe - held_safe;
    for (int k = 1; k <= Phases; k++) begin
      v        = held_safe + (delta * k) / Phases;
      e.sample = v[OUT_W-1:0];
      e.last   = (k == Phases);
      pending_pcm_q.push_back(e);
    end
    held_safe = safe;
  endfunction

  // Offer one sample, idling first at random, and predict once it is taken.
  task automatic send_sample(input logic signed [IN_W-1:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_sample_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_interp_group(s);
  endtask

  // Random sample, weighted toward the clamp edge, small steps and full scale.
  function automatic logic signed [IN_W-1:0] random_sample();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = int'($urandom_range(65535)) - 32768;
      4, 5:       v = int'($urandom_range(33334)) - 16667;
      6:          v = (int'($urandom_range(40)) + 16647) * ($urandom_range(1) ? 1 : -1);
      7:          v = int'($urandom_range(40)) - 20;
      8:          v = $urandom_range(1) ? 32767 : -32768;
      default:    v = held_safe;
    endcase
    return v[IN_W-1:0];
  endfunction

  task automatic run_random_samples(input int count);
    repeat (count) send_sample(random_sample());
  endtask

  // Full-scale inputs and alternating bit patterns.
  task automatic test_full_scale();
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    send_sample(-16'sd32768);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(16'sh8001);
  endtask

  // Inputs on either side of the point where the scaled value reaches the clamp.
  task automatic test_clamp_threshold();
    send_sample(16'sd16666);
    send_sample(16'sd16667);
    send_sample(-16'sd16667);
    send_sample(-16'sd16666);
    send_sample(16'sd16668);
    send_sample(-16'sd16668);
  endtask

  // Small values whose steps do not divide evenly, to expose rounding toward zero.
  task automatic test_truncation();
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd2);
    send_sample(16'sd5);
    send_sample(-16'sd5);
    send_sample(16'sd9);
    send_sample(-16'sd9);
    send_sample(16'sd17);
    send_sample(-16'sd17);
  endtask

  // Receiver stalls most of the time while the sender is nearly always ready.
  task automatic test_backpressure();
    src_idle_pct  = 12;
    snk_stall_pct = 79;
    run_random_samples(70);
  endtask

  // Sender idles most of the time while the receiver rarely stalls.
  task automatic test_sparse_input();
    src_idle_pct  = 79;
    snk_stall_pct = 12;
    run_random_samples(70);
  endtask

  // Neither side idles, so the block runs at its full rate.
  task automatic test_full_throughput();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    run_random_samples(67);
  endtask

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < snk_stall_pct);
  end

  // Compare every accepted output item with the oldest expectation.
  always @(posedge clk_i) begin
    pcm_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pcm_q.size() == 0) begin
        $error("unexpected item: out_sample %0d last %0b", out_sample_o, last_o);
        fail_count++;
      end else begin
        e = pending_pcm_q.pop_front();
        if (out_sample_o !== e.sample) begin
          $error("out_sample: expected %0d, actual %0d", e.sample, out_sample_o);
          fail_count++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0b, actual %0b", e.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_scale();
    test_clamp_threshold();
    test_truncation();
    test_backpressure();
    test_sparse_input();
    test_full_throughput();
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then let the pipeline settle.
    while (pending_pcm_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gclu_pkg.sv
rtl/gclu_front.sv
rtl/gclu_fifo.sv
rtl/gclu_back.sv
rtl/gain_clamp_linear_upsampler_x6.sv
rtl/gclu_checker.sv
tb/tb_gain_clamp_linear_upsampler_x6.sv
